FILE: hdl/wfhf_pkg.sv
// Package for the 802.11 frame header filter: register codes, result record,
// and the type/subtype filter function. No dependencies.
package wfhf_pkg;

  localparam int unsigned ADDR_BYTES = 6;
  localparam logic [15:0] LEN_MAX    = 16'hFFFF;
  localparam logic [15:0] LEN_MIN    = 16'd2;
  localparam logic [15:0] LEN_MAC    = 16'd16;
  localparam logic [15:0] LEN_BSSID  = 16'd22;
  localparam logic [4:0]  OFF_ADDR1  = 5'd4;
  localparam logic [4:0]  OFF_ADDR2  = 5'd10;
  localparam logic [4:0]  OFF_ADDR3  = 5'd16;

  localparam logic [1:0] TYPE_MGMT = 2'd0;
  localparam logic [1:0] TYPE_CTRL = 2'd1;
  localparam logic [1:0] TYPE_DATA = 2'd2;

  localparam logic [3:0] SUB_ASSOC_REQ = 4'd0;
  localparam logic [3:0] SUB_ASSOC_RSP = 4'd1;
  localparam logic [3:0] SUB_PROBE_REQ = 4'd4;
  localparam logic [3:0] SUB_PROBE_RSP = 4'd5;
  localparam logic [3:0] SUB_BEACON    = 4'd8;
  localparam logic [3:0] SUB_DISASSOC  = 4'd10;
  localparam logic [3:0] SUB_AUTH      = 4'd11;
  localparam logic [3:0] SUB_DEAUTH    = 4'd12;

  typedef enum logic [3:0] {
    FILT_ALL       = 4'd0,
    FILT_MGMT      = 4'd1,
    FILT_CTRL      = 4'd2,
    FILT_DATA      = 4'd3,
    FILT_BEACON    = 4'd4,
    FILT_PROBE_REQ = 4'd5,
    FILT_PROBE_RSP = 4'd6,
    FILT_AUTH      = 4'd7,
    FILT_DEAUTH    = 4'd8,
    FILT_ASSOC     = 4'd9,
    FILT_DISASSOC  = 4'd10,
    FILT_QOS       = 4'd11
  } filt_e;

  typedef enum logic [1:0] {
    MAC_OFF   = 2'd0,
    MAC_ADDR2 = 2'd1,
    MAC_ADDR1 = 2'd2,
    MAC_ADDR3 = 2'd3
  } mac_mode_e;

  typedef enum logic [1:0] {
    REG_FRAME_FILTER   = 2'd0,
    REG_MAC_MODE       = 2'd1,
    REG_MAC_MATCH_ADDR = 2'd2
  } reg_idx_e;

  typedef struct packed {
    filt_e       frame_filter;
    mac_mode_e   mac_mode;
    logic [47:0] mac_match_addr;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] frame_length;
    logic [1:0]  frame_type;
    logic [3:0]  frame_subtype;
    logic [31:0] accepted_bytes_total;
  } result_t;

  function automatic logic type_passes(filt_e filt, logic [1:0] ftype, logic [3:0] fsub);
    logic mg;
    mg = (ftype == TYPE_MGMT);
    unique case (filt)
      FILT_ALL:       return 1'b1;
      FILT_MGMT:      return mg;
      FILT_CTRL:      return ftype == TYPE_CTRL;
      FILT_DATA:      return ftype == TYPE_DATA;
      FILT_BEACON:    return mg && fsub == SUB_BEACON;
      FILT_PROBE_REQ: return mg && fsub == SUB_PROBE_REQ;
      FILT_PROBE_RSP: return mg && fsub == SUB_PROBE_RSP;
      FILT_AUTH:      return mg && fsub == SUB_AUTH;
      FILT_DEAUTH:    return mg && fsub == SUB_DEAUTH;
      FILT_ASSOC:     return mg && (fsub == SUB_ASSOC_REQ || fsub == SUB_ASSOC_RSP);
      FILT_DISASSOC:  return mg && fsub == SUB_DISASSOC;
      FILT_QOS:       return ftype == TYPE_DATA && fsub[3];
      default:        return 1'b1;
    endcase
  endfunction

endpackage

FILE: hdl/wfhf_if.sv
// Channel interfaces for the frame header filter: byte input, result output
// and register write. No dependencies.
interface wfhf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface wfhf_result_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [15:0] frame_length;
  logic [1:0]  frame_type;
  logic [3:0]  frame_subtype;
  logic [31:0] accepted_bytes_total;
  modport source (output valid, accepted, frame_length, frame_type, frame_subtype,
                  accepted_bytes_total, input ready);
  modport sink   (input valid, accepted, frame_length, frame_type, frame_subtype,
                  accepted_bytes_total, output ready);
endinterface

interface wfhf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/wfhf_cfg_regs.sv
// Configuration registers of the frame header filter, written through the
// register write channel. Depends on wfhf_pkg and wfhf_if.
module wfhf_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  wfhf_cfg_if.sink      cfg_i,
  output wfhf_pkg::cfg_t cfg_o
);

  wfhf_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (wfhf_pkg::reg_idx_e'(cfg_i.index))
        wfhf_pkg::REG_FRAME_FILTER:
          cfg_d.frame_filter = wfhf_pkg::filt_e'(cfg_i.data[3:0]);
        wfhf_pkg::REG_MAC_MODE:
          cfg_d.mac_mode = wfhf_pkg::mac_mode_e'(cfg_i.data[1:0]);
        wfhf_pkg::REG_MAC_MATCH_ADDR:
          cfg_d.mac_match_addr = cfg_i.data;
        default: ;  // unknown register: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{frame_filter: wfhf_pkg::FILT_ALL, mac_mode: wfhf_pkg::MAC_OFF,
                 mac_match_addr: 48'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/wfhf_parser.sv
// Input register and per-frame state of the frame header filter; decides
// pass or reject on the last byte. Depends on wfhf_pkg and wfhf_if.
module wfhf_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  wfhf_byte_if.sink          in_i,
  input  wfhf_pkg::cfg_t     cfg_i,
  input  logic               res_free_i,
  output logic               res_valid_o,
  output wfhf_pkg::result_t  res_o
);

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;

  // frame state
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic        eq_q, eq_d;
  logic [31:0] total_q, total_d;

  logic        advance;
  logic [7:0]  ctrl_cur;
  logic [4:0]  off;
  logic [15:0] rel;
  logic        in_addr;
  logic [7:0]  want;
  logic        eq_cur;
  logic [15:0] cnt_inc;
  logic [1:0]  ftype;
  logic [3:0]  fsub;
  logic        mac_apply;
  logic        ok;

  // a non-last byte always moves on; the last one needs the result slot free
  assign advance  = s1_valid_q && (!s1_last_q || res_free_i);
  assign in_i.ready = !s1_valid_q || advance;

  always_comb begin
    unique case (cfg_i.mac_mode)
      wfhf_pkg::MAC_OFF:   off = 5'd0;
      wfhf_pkg::MAC_ADDR2: off = wfhf_pkg::OFF_ADDR2;
      wfhf_pkg::MAC_ADDR1: off = wfhf_pkg::OFF_ADDR1;
      wfhf_pkg::MAC_ADDR3: off = wfhf_pkg::OFF_ADDR3;
      default:             off = 5'd0;
    endcase
  end

  assign rel     = cnt_q - {11'd0, off};
  assign in_addr = (off != 5'd0) && (cnt_q >= {11'd0, off})
                   && (rel < 16'(wfhf_pkg::ADDR_BYTES));

  // first transmitted address byte sits in the top bits
  always_comb begin
    unique case (rel[2:0])
      3'd0:    want = cfg_i.mac_match_addr[47:40];
      3'd1:    want = cfg_i.mac_match_addr[39:32];
      3'd2:    want = cfg_i.mac_match_addr[31:24];
      3'd3:    want = cfg_i.mac_match_addr[23:16];
      3'd4:    want = cfg_i.mac_match_addr[15:8];
      default: want = cfg_i.mac_match_addr[7:0];
    endcase
  end

  assign ctrl_cur = (cnt_q == 16'd0) ? s1_byte_q : ctrl_q;
  assign eq_cur   = eq_q && !(in_addr && (want != s1_byte_q));
  assign cnt_inc  = (cnt_q != wfhf_pkg::LEN_MAX) ? cnt_q + 16'd1 : cnt_q;
  assign ftype    = ctrl_cur[3:2];
  assign fsub     = ctrl_cur[7:4];

  assign mac_apply = (cfg_i.mac_mode != wfhf_pkg::MAC_OFF) && (cnt_inc >= wfhf_pkg::LEN_MAC)
                     && (cfg_i.mac_mode != wfhf_pkg::MAC_ADDR3
                         || cnt_inc >= wfhf_pkg::LEN_BSSID);

  always_comb begin
    priority if (cnt_inc < wfhf_pkg::LEN_MIN) begin
      ok = 1'b0;
    end else if (!wfhf_pkg::type_passes(cfg_i.frame_filter, ftype, fsub)) begin
      ok = 1'b0;
    end else if (mac_apply) begin
      ok = eq_cur;
    end else begin
      ok = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    cnt_d      = cnt_q;
    ctrl_d     = ctrl_q;
    eq_d       = eq_q;
    total_d    = total_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end
    if (advance) begin
      if (s1_last_q) begin
        cnt_d   = 16'd0;
        ctrl_d  = 8'd0;
        eq_d    = 1'b1;
        total_d = ok ? total_q + {16'd0, cnt_inc} : total_q;
      end else begin
        cnt_d  = cnt_inc;
        ctrl_d = ctrl_cur;
        eq_d   = eq_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cnt_q      <= 16'd0;
      ctrl_q     <= 8'd0;
      eq_q       <= 1'b1;
      total_q    <= 32'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      cnt_q      <= cnt_d;
      ctrl_q     <= ctrl_d;
      eq_q       <= eq_d;
      total_q    <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.frame_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  assign res_valid_o = advance && s1_last_q;
  assign res_o = '{accepted: ok, frame_length: cnt_inc, frame_type: ftype,
                   frame_subtype: fsub, accepted_bytes_total: total_d};

endmodule

FILE: hdl/wfhf_out_reg.sv
// Result register of the frame header filter: holds one result until the
// receiver takes it. Depends on wfhf_pkg and wfhf_if.
module wfhf_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  wfhf_pkg::result_t res_i,
  output logic              res_free_o,
  wfhf_result_if.source     out_o
);

  logic              valid_q, valid_d;
  wfhf_pkg::result_t res_q;

  assign res_free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_free_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid                = valid_q;
  assign out_o.accepted             = res_q.accepted;
  assign out_o.frame_length         = res_q.frame_length;
  assign out_o.frame_type           = res_q.frame_type;
  assign out_o.frame_subtype        = res_q.frame_subtype;
  assign out_o.accepted_bytes_total = res_q.accepted_bytes_total;

endmodule

FILE: hdl/wifi_frame_header_filter.sv
// 802.11 frame type/subtype and address filter, top level.
// Channels: in_i takes one frame byte per request with a last-byte mark,
// starting at frame control; out_o gives one result per frame (pass flag,
// length, type, subtype, running total of accepted bytes); cfg_i writes
// register 0 frame filter, 1 address mode, 2 match address.
// Throughput: one byte per cycle, frames back to back, while no held result stalls.
// Path: a last byte is captured in the input register, then the decision
// logic loads its result into the result register, which drives out_o.
// Reset clears the registers, the frame state and the total, and empties
// both stages. When out_o stalls, bytes that are not last keep flowing; a
// last byte waits in the input register and in_i drops ready until the
// held result is taken.
// Depends on wfhf_pkg, wfhf_if, wfhf_cfg_regs, wfhf_parser, wfhf_out_reg.
module wifi_frame_header_filter (
  input  logic          clk_i,
  input  logic          rst_ni,
  wfhf_byte_if.sink     in_i,
  wfhf_result_if.source out_o,
  wfhf_cfg_if.sink      cfg_i
);

  wfhf_pkg::cfg_t    cfg;
  wfhf_pkg::result_t res;
  logic              res_valid;
  logic              res_free;

  wfhf_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  wfhf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wfhf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_free_o  (res_free),
    .out_o       (out_o)
  );

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without a held result");

  a_pass_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.accepted) |-> (out_o.frame_length >= wfhf_pkg::LEN_MIN))
    else $error("frame shorter than two bytes passed");

  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_free)
    else $error("result produced while result register busy");

endmodule
